// File: src/frustum_sphere_culler_macros.svh
// Assertion macros used by the frustum sphere culler controller.
// Included by files that check their own control behavior; no other dependencies.
`ifndef FRUSTUM_SPHERE_CULLER_MACROS_SVH
`define FRUSTUM_SPHERE_CULLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum sphere culler check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum sphere culler check failed");

`endif

// File: src/fsc_pkg.sv
// Shared types, constants and arithmetic helpers of the frustum sphere culler.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned NumComps   = 4;
  localparam int unsigned DataW      = 32;
  localparam int unsigned IndexW     = 16;
  localparam int unsigned LimitW     = 17;
  localparam int unsigned RadiusW    = 31;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned MaxObjects = 65536;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned DivSteps   = 33;

  // Squared normal length below which a plane is left unnormalized.
  localparam logic signed [65:0] LenSqMin = 66'sd43;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_e;

  typedef enum logic [0:0] {
    CFG_CULL_ENABLE  = 1'b0,
    CFG_OBJECT_LIMIT = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    MUL_SPHERE = 2'd0,
    MUL_SQUARE = 2'd1,
    MUL_SCALE  = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_MUL,
    S_T_CMP,
    S_EMIT,
    S_D_RAW,
    S_D_SQ,
    S_D_CHK,
    S_D_SQRT,
    S_D_DIVI,
    S_D_DIV,
    S_D_SC,
    S_D_WR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic [2:0] plane;
    logic [1:0] comp;
    logic [1:0] wr_comp;
    logic       acc_load;
    logic       acc_add;
    logic       raw_load;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       scale_wr;
    logic       plane_wr;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic slot_last;
    logic cull_en;
    logic over_limit;
    logic len_ok;
    logic culled;
    logic out_free;
  } status_t;

  // Saturate a 33-bit signed sum to signed 32 bits.
  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a magnitude product by 2^16 half away from zero, apply sign, saturate.
  function automatic logic [31:0] scale_round(input logic [63:0] prod, input logic neg);
    logic [63:0] sum;
    logic [47:0] q;
    logic [31:0] r;
    sum = prod + 64'd32768;
    q   = sum[63:16];
    if (neg) begin
      r = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      r = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/fsc_datapath.sv
// Datapath of the frustum sphere culler: matrix and plane stores, shared multiplier,
// square root and reciprocal units, sphere distance test and output register. Uses fsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsc_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire fsc_pkg::cmd_t                    cmd_i,
  output fsc_pkg::status_t                      sts_o,
  input  wire                                   action_i,
  input  wire [fsc_pkg::SlotW-1:0]              matrix_slot_i,
  input  wire [fsc_pkg::DataW-1:0]              matrix_value_i,
  input  wire [fsc_pkg::IndexW-1:0]             object_index_i,
  input  wire [fsc_pkg::DataW-1:0]              center_x_i,
  input  wire [fsc_pkg::DataW-1:0]              center_y_i,
  input  wire [fsc_pkg::DataW-1:0]              center_z_i,
  input  wire [fsc_pkg::RadiusW-1:0]            sphere_radius_i,
  input  wire                                   cfg_valid_i,
  input  wire [0:0]                             cfg_index_i,
  input  wire [fsc_pkg::LimitW-1:0]             cfg_data_i,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic [fsc_pkg::IndexW-1:0]            visible_index_o
);

  logic [31:0] matrix_q [16];
  logic [31:0] plane_q [fsc_pkg::NumPlanes][fsc_pkg::NumComps];
  logic [31:0] p_q [fsc_pkg::NumComps];
  logic [31:0] p_d [fsc_pkg::NumComps];

  logic [fsc_pkg::IndexW-1:0]  idx_q;
  logic [31:0]                 cx_q, cy_q, cz_q;
  logic [fsc_pkg::RadiusW-1:0] rad_q;

  logic                        cull_en_q;
  logic [fsc_pkg::LimitW-1:0]  limit_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, prod_q, acc_q;

  logic [63:0] x_q, r_q, bit_q;
  logic [64:0] sq_t;
  logic [31:0] len_q, rem_q, inv_q;
  logic [32:0] num_q, div_rs;

  logic [31:0] sel_center, sel_mag;
  logic [51:0] margin;

  logic        out_valid_q;
  logic [fsc_pkg::IndexW-1:0] out_idx_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q <= 1'b1;
      limit_q   <= fsc_pkg::LimitW'(fsc_pkg::MaxObjects);
    end else if (cfg_valid_i) begin
      case (fsc_pkg::cfg_index_e'(cfg_index_i))
        fsc_pkg::CFG_CULL_ENABLE:  cull_en_q <= cfg_data_i[0];
        fsc_pkg::CFG_OBJECT_LIMIT: limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Matrix store, written by load beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
    end else if (cmd_i.accept && (action_i == fsc_pkg::ACT_LOAD)) begin
      matrix_q[matrix_slot_i] <= matrix_value_i;
    end
  end

  // Sphere fields captured on every accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= object_index_i;
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      cz_q  <= center_z_i;
      rad_q <= sphere_radius_i;
    end
  end

  // Raw plane row: row3 plus or minus row k, saturated.
  always_comb begin
    logic [3:0]  wi, ei;
    logic [32:0] w, e;
    for (int j = 0; j < fsc_pkg::NumComps; j++) begin
      wi = 4'(4 * j + 3);
      ei = 4'(4 * j) | {2'b00, cmd_i.plane[2:1]};
      w  = {matrix_q[wi][31], matrix_q[wi]};
      e  = {matrix_q[ei][31], matrix_q[ei]};
      p_d[j] = fsc_pkg::sat32(cmd_i.plane[0] ? (w - e) : (w + e));
    end
  end

  // Plane working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.raw_load) begin
      for (int j = 0; j < fsc_pkg::NumComps; j++) p_q[j] <= p_d[j];
    end else if (cmd_i.scale_wr) begin
      p_q[cmd_i.wr_comp] <= fsc_pkg::scale_round(prod_q[63:0], p_q[cmd_i.wr_comp][31]);
    end
  end

  // Plane store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fsc_pkg::NumPlanes; i++) begin
        for (int j = 0; j < fsc_pkg::NumComps; j++) plane_q[i][j] <= '0;
      end
    end else if (cmd_i.plane_wr) begin
      for (int j = 0; j < fsc_pkg::NumComps; j++) plane_q[cmd_i.plane][j] <= p_q[j];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.comp)
      2'd0:    sel_center = cx_q;
      2'd1:    sel_center = cy_q;
      default: sel_center = cz_q;
    endcase
    sel_mag = p_q[cmd_i.comp][31] ? (~p_q[cmd_i.comp] + 32'd1) : p_q[cmd_i.comp];
    case (cmd_i.mul_sel)
      fsc_pkg::MUL_SPHERE: begin
        mul_a = {plane_q[cmd_i.plane][cmd_i.comp][31], plane_q[cmd_i.plane][cmd_i.comp]};
        mul_b = {sel_center[31], sel_center};
      end
      fsc_pkg::MUL_SQUARE: begin
        mul_a = {p_q[cmd_i.comp][31], p_q[cmd_i.comp]};
        mul_b = {p_q[cmd_i.comp][31], p_q[cmd_i.comp]};
      end
      fsc_pkg::MUL_SCALE: begin
        mul_a = {1'b0, sel_mag};
        mul_b = {1'b0, inv_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Product register and accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= prod;
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Integer square root, one result bit per step.
  assign sq_t = {1'b0, r_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      x_q   <= acc_q[63:0];
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, x_q} >= sq_t) begin
        x_q <= x_q - sq_t[63:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Restoring divider for the rounded reciprocal of the length.
  assign div_rs = {rem_q, num_q[32]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      len_q <= r_q[31:0];
      num_q <= 33'h1_0000_0000 + {2'b00, r_q[31:1]};
      rem_q <= '0;
      inv_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_rs >= {1'b0, len_q}) begin
        rem_q <= 32'(div_rs - {1'b0, len_q});
        inv_q <= {inv_q[30:0], 1'b1};
      end else begin
        rem_q <= div_rs[31:0];
        inv_q <= {inv_q[30:0], 1'b0};
      end
      num_q <= {num_q[31:0], 1'b0};
    end
  end

  // Distance plus radius; negative means the sphere lies outside this plane.
  assign margin = {{2{acc_q[65]}}, acc_q[65:16]}
                + {{20{plane_q[cmd_i.plane][3][31]}}, plane_q[cmd_i.plane][3]}
                + {21'b0, rad_q};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_idx_q <= idx_q;
  end

  assign out_valid_o     = out_valid_q;
  assign visible_index_o = out_idx_q;

  // Status toward the controller.
  assign sts_o.is_load    = (action_i == fsc_pkg::ACT_LOAD);
  assign sts_o.slot_last  = (matrix_slot_i == {fsc_pkg::SlotW{1'b1}});
  assign sts_o.cull_en    = cull_en_q;
  assign sts_o.over_limit = ({1'b0, object_index_i} >= limit_q);
  assign sts_o.len_ok     = (acc_q >= fsc_pkg::LenSqMin);
  assign sts_o.culled     = margin[51];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: src/fsc_ctrl.sv
// Controller of the frustum sphere culler: sequences plane derivation and sphere tests.
// Uses fsc_pkg and the assertion macros in frustum_sphere_culler_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_sphere_culler_macros.svh"

module fsc_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire fsc_pkg::status_t   sts_i,
  output fsc_pkg::cmd_t           cmd_o
);

  fsc_pkg::state_e state_q, state_d;
  logic [2:0] plane_q, plane_d;
  logic [5:0] cnt_q, cnt_d;
  logic       accept;

  assign in_ready_o = (state_q == fsc_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsc_pkg::S_IDLE;
      plane_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    cnt_d   = cnt_q + 6'd1;
    case (state_q)
      fsc_pkg::S_IDLE: begin
        plane_d = '0;
        cnt_d   = '0;
        if (accept) begin
          if (sts_i.is_load) begin
            if (sts_i.slot_last) state_d = fsc_pkg::S_D_RAW;
          end else if (!sts_i.cull_en) begin
            state_d = fsc_pkg::S_EMIT;
          end else if (!sts_i.over_limit) begin
            state_d = fsc_pkg::S_T_MUL;
          end
        end
      end
      fsc_pkg::S_T_MUL: begin
        if (cnt_q == 6'd3) state_d = fsc_pkg::S_T_CMP;
      end
      fsc_pkg::S_T_CMP: begin
        cnt_d = '0;
        if (sts_i.culled) begin
          state_d = fsc_pkg::S_IDLE;
        end else if (plane_q == 3'(fsc_pkg::NumPlanes - 1)) begin
          state_d = fsc_pkg::S_EMIT;
        end else begin
          plane_d = plane_q + 3'd1;
          state_d = fsc_pkg::S_T_MUL;
        end
      end
      fsc_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = fsc_pkg::S_IDLE;
      end
      fsc_pkg::S_D_RAW: begin
        cnt_d   = '0;
        state_d = fsc_pkg::S_D_SQ;
      end
      fsc_pkg::S_D_SQ: begin
        if (cnt_q == 6'd3) state_d = fsc_pkg::S_D_CHK;
      end
      fsc_pkg::S_D_CHK: begin
        cnt_d   = '0;
        state_d = sts_i.len_ok ? fsc_pkg::S_D_SQRT : fsc_pkg::S_D_WR;
      end
      fsc_pkg::S_D_SQRT: begin
        if (cnt_q == 6'(fsc_pkg::SqrtSteps - 1)) state_d = fsc_pkg::S_D_DIVI;
      end
      fsc_pkg::S_D_DIVI: begin
        cnt_d   = '0;
        state_d = fsc_pkg::S_D_DIV;
      end
      fsc_pkg::S_D_DIV: begin
        if (cnt_q == 6'(fsc_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = fsc_pkg::S_D_SC;
        end
      end
      fsc_pkg::S_D_SC: begin
        if (cnt_q == 6'd4) state_d = fsc_pkg::S_D_WR;
      end
      fsc_pkg::S_D_WR: begin
        cnt_d = '0;
        if (plane_q == 3'(fsc_pkg::NumPlanes - 1)) begin
          state_d = fsc_pkg::S_IDLE;
        end else begin
          plane_d = plane_q + 3'd1;
          state_d = fsc_pkg::S_D_RAW;
        end
      end
      default: state_d = fsc_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.plane   = plane_q;
    cmd_o.comp    = cnt_q[1:0];
    cmd_o.wr_comp = cnt_q[1:0] - 2'd1;
    cmd_o.mul_sel = fsc_pkg::MUL_SPHERE;
    case (state_q)
      fsc_pkg::S_IDLE: cmd_o.accept = accept;
      fsc_pkg::S_T_MUL: begin
        cmd_o.mul_en   = (cnt_q < 6'd3);
        cmd_o.acc_load = (cnt_q == 6'd1);
        cmd_o.acc_add  = (cnt_q >= 6'd2);
      end
      fsc_pkg::S_EMIT: cmd_o.out_load = sts_i.out_free;
      fsc_pkg::S_D_RAW: cmd_o.raw_load = 1'b1;
      fsc_pkg::S_D_SQ: begin
        cmd_o.mul_sel  = fsc_pkg::MUL_SQUARE;
        cmd_o.mul_en   = (cnt_q < 6'd3);
        cmd_o.acc_load = (cnt_q == 6'd1);
        cmd_o.acc_add  = (cnt_q >= 6'd2);
      end
      fsc_pkg::S_D_CHK: cmd_o.sqrt_init = sts_i.len_ok;
      fsc_pkg::S_D_SQRT: cmd_o.sqrt_step = 1'b1;
      fsc_pkg::S_D_DIVI: cmd_o.div_init = 1'b1;
      fsc_pkg::S_D_DIV: cmd_o.div_step = 1'b1;
      fsc_pkg::S_D_SC: begin
        cmd_o.mul_sel  = fsc_pkg::MUL_SCALE;
        cmd_o.mul_en   = (cnt_q < 6'd4);
        cmd_o.scale_wr = (cnt_q >= 6'd1);
      end
      fsc_pkg::S_D_WR: cmd_o.plane_wr = 1'b1;
      default: ;
    endcase
  end

  // A load that does not complete the matrix leaves the block ready.
  `FSC_ASSERT_NEXT(a_load_returns, clk_i, rst_ni, accept && sts_i.is_load && !sts_i.slot_last, in_ready_o)
  // Completing the matrix starts plane derivation and blocks input.
  `FSC_ASSERT_NEXT(a_derive_blocks, clk_i, rst_ni, accept && sts_i.is_load && sts_i.slot_last, !in_ready_o)
  // With culling off a sphere goes straight to the output stage.
  `FSC_ASSERT_NEXT(a_cull_off_emits, clk_i, rst_ni, accept && !sts_i.is_load && !sts_i.cull_en, state_q == fsc_pkg::S_EMIT)
  // The plane counter never passes the last plane.
  `FSC_ASSERT_SAME(a_plane_range, clk_i, rst_ni, 1'b1, plane_q < 3'(fsc_pkg::NumPlanes))

endmodule

`default_nettype wire

// File: src/frustum_sphere_culler.sv
// Frustum sphere culler. A matrix load beat leaves the block ready, but the beat that writes
// slot 15 also derives the six planes, which holds off input until every plane is written;
// a normalized plane goes through the 32-step square root and the 33-step reciprocal
// divider, a degenerate plane skips both. A sphere beat holds off input while the planes are
// tested one after another on one shared 33x33 multiplier, and while it waits for the output
// register. Rejected spheres return sooner. Configuration writes are always ready.
// Uses fsc_pkg, fsc_ctrl and fsc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module frustum_sphere_culler (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           action_i,
  input  wire [fsc_pkg::SlotW-1:0]      matrix_slot_i,
  input  wire signed [fsc_pkg::DataW-1:0] matrix_value_i,
  input  wire [fsc_pkg::IndexW-1:0]     object_index_i,
  input  wire signed [fsc_pkg::DataW-1:0] center_x_i,
  input  wire signed [fsc_pkg::DataW-1:0] center_y_i,
  input  wire signed [fsc_pkg::DataW-1:0] center_z_i,
  input  wire [fsc_pkg::RadiusW-1:0]    sphere_radius_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [fsc_pkg::IndexW-1:0]    visible_index_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [0:0]                     cfg_index_i,
  input  wire [fsc_pkg::LimitW-1:0]     cfg_data_i
);

  fsc_pkg::cmd_t    cmd;
  fsc_pkg::status_t sts;

  // Register writes are always accepted.
  assign cfg_ready_o = 1'b1;

  fsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .matrix_slot_i   (matrix_slot_i),
    .matrix_value_i  (matrix_value_i),
    .object_index_i  (object_index_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .sphere_radius_i (sphere_radius_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .visible_index_o (visible_index_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_frustum_sphere_culler.sv
// Self-checking testbench for the frustum sphere culler: matrix loads, plane derivation,
// sphere tests and both configuration registers, checked against an in-bench predictor.
// Depends on fsc_pkg and frustum_sphere_culler.
`timescale 1ns / 1ps

module tb_frustum_sphere_culler;

  localparam int unsigned SettleCycles = 600;
  localparam int unsigned StallLimit   = 6000;
  localparam int unsigned LongHold     = 300;

  typedef struct packed {
    fsc_pkg::action_e    action;
    logic [3:0]          slot;
    logic signed [31:0]  value;
    logic [15:0]         index;
    logic signed [31:0]  cx;
    logic signed [31:0]  cy;
    logic signed [31:0]  cz;
    logic [30:0]         radius;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  beat_t               cur = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [15:0]         visible_index;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  fsc_pkg::cfg_index_e cfg_index = fsc_pkg::CFG_CULL_ENABLE;
  logic [16:0]         cfg_data = '0;

  // Predictor state.
  logic signed [31:0] mat_m [16];
  logic signed [31:0] plane_m [24];
  logic               cull_m = 1'b1;
  logic [16:0]        limit_m = 17'd65536;

  beat_t       pending_q[$];
  logic [15:0] visible_q[$];
  int          errors = 0;
  int          n_loads = 0, n_tests = 0, n_seen = 0;
  logic        in_fire_q = 1'b0;
  int          gap_left = 0;
  logic        quiet = 1'b0;
  int          hold_reqs = 0, hold_seen = 0, hold_left = 0, rdy_gap = 0;
  int          stall_cnt = 0;

  always #4 clk_i = ~clk_i;

  frustum_sphere_culler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (cur.action),
    .matrix_slot_i   (cur.slot),
    .matrix_value_i  (cur.value),
    .object_index_i  (cur.index),
    .center_x_i      (cur.cx),
    .center_y_i      (cur.cy),
    .center_z_i      (cur.cz),
    .sphere_radius_i (cur.radius),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .visible_index_o (visible_index),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Append one beat to the list waiting for the driver.
  task automatic enqueue(beat_t b);
    pending_q = {pending_q, b};
  endtask

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x = x - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // Build the six planes from the current matrix and normalize the usable ones.
  task automatic derive_planes();
    longint p [4];
    longint unsigned s, len, inv, m, q;
    longint w, e;
    int k;
    for (int i = 0; i < 6; i++) begin
      k = i / 2;
      for (int j = 0; j < 4; j++) begin
        w = mat_m[4*j+3];
        e = mat_m[4*j+k];
        p[j] = sat_s32((i % 2 == 1) ? w - e : w + e);
      end
      s = 0;
      for (int j = 0; j < 3; j++) begin
        m = (p[j] < 0) ? -p[j] : p[j];
        s += m * m;
      end
      if (s >= 43) begin
        len = int_sqrt(s);
        inv = ((64'd1 << 32) + (len >> 1)) / len;
        for (int j = 0; j < 4; j++) begin
          m = (p[j] < 0) ? -p[j] : p[j];
          q = (m * inv + 64'd32768) >> 16;
          p[j] = sat_s32((p[j] < 0) ? -longint'(q) : longint'(q));
        end
      end
      for (int j = 0; j < 4; j++) plane_m[4*i+j] = p[j][31:0];
    end
  endtask

  function automatic logic sphere_inside(beat_t b);
    longint c [3];
    longint hi, lo, prod, h, dist_v;
    c[0] = b.cx;
    c[1] = b.cy;
    c[2] = b.cz;
    for (int i = 0; i < 6; i++) begin
      hi = 0;
      lo = 0;
      for (int j = 0; j < 3; j++) begin
        prod = longint'(plane_m[4*i+j]) * c[j];
        h = prod >>> 16;
        hi += h;
        lo += prod - h * 65536;
      end
      dist_v = hi + longint'(plane_m[4*i+3]) + (lo >>> 16);
      if (dist_v < -longint'({33'd0, b.radius})) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted beat to the predictor and queue any visible index.
  task automatic predict_beat(beat_t b);
    if (b.action == fsc_pkg::ACT_LOAD) begin
      n_loads++;
      mat_m[b.slot] = b.value;
      if (b.slot == 4'd15) derive_planes();
    end else begin
      n_tests++;
      if (!cull_m || ({1'b0, b.index} < limit_m && sphere_inside(b)))
        visible_q = {visible_q, b.index};
    end
  endtask

  // Input acceptance, result checking and the stall watchdog.
  always @(posedge clk_i) begin
    in_fire_q <= in_valid && in_ready;
    if (in_valid && in_ready) predict_beat(cur);
    if (out_valid && out_ready) begin
      n_seen++;
      if (visible_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected visible index, expected none, got %0d",
                 $time, visible_index);
      end else begin
        if (visible_index !== visible_q[0]) begin
          errors++;
          $display("%0t: visible_index mismatch, expected %0d, got %0d",
                   $time, visible_q[0], visible_index);
        end
        void'(visible_q.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Input driver: holds a beat until it is taken, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_fire_q)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          cur <= pending_q.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready: random short stalls plus a long hold when requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap <= rdy_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rdy_gap <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic beat_t load_beat(int slot, logic signed [31:0] value);
    beat_t b;
    b = '0;
    b.action = fsc_pkg::ACT_LOAD;
    b.slot = slot[3:0];
    b.value = value;
    b.index = 16'($urandom);
    return b;
  endfunction

  function automatic beat_t test_beat(logic [15:0] index, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z,
                                      logic [30:0] r);
    beat_t b;
    b.action = fsc_pkg::ACT_TEST;
    b.slot = 4'($urandom);
    b.value = $urandom;
    b.index = index;
    b.cx = x;
    b.cy = y;
    b.cz = z;
    b.radius = r;
    return b;
  endfunction

  // Matrix element: mostly a few units in size, sometimes any 32-bit value.
  function automatic logic signed [31:0] rand_elem();
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 4) == 0) return 0;
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  function automatic beat_t rand_test();
    logic [30:0] r;
    r = ($urandom_range(0, 15) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 19));
    return test_beat(16'($urandom), rand_coord(), rand_coord(), rand_coord(), r);
  endfunction

  // Full matrix in shuffled order, slot 15 last so the planes see every element.
  task automatic queue_matrix();
    int order [15];
    int t, j;
    for (int i = 0; i < 15; i++) order[i] = i;
    for (int i = 14; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 15; i++) enqueue(load_beat(order[i], rand_elem()));
    enqueue(load_beat(15, rand_elem()));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || visible_q.size() != 0 || hold_left != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(fsc_pkg::cfg_index_e idx, logic [16:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == fsc_pkg::CFG_CULL_ENABLE) cull_m = data[0];
    else limit_m = data;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int n;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          queue_matrix();
          n += 16;
        end
        2: begin
          enqueue(load_beat($urandom_range(0, 15), rand_elem()));
          n++;
        end
        default: begin
          enqueue(rand_test());
          n++;
        end
      endcase
    end
  endtask

  initial begin
    foreach (mat_m[i]) mat_m[i] = '0;
    foreach (plane_m[i]) plane_m[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero planes after reset: every sphere is visible, field extremes included.
    enqueue(test_beat(16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 31'd0));
    enqueue(test_beat(16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh8000_0000, 31'h7FFF_FFFF));
    // Partial matrix: only slot 15 written, degenerate planes stay raw.
    enqueue(load_beat(15, 32'sh0001_0000));
    enqueue(test_beat(16'd5, 0, 0, 32'sh0010_0000, 31'd0));
    enqueue(test_beat(16'd6, 0, 0, 32'sh8000_0000, 31'd0));
    // Identity matrix: unit cube frustum.
    for (int i = 0; i < 16; i++)
      enqueue(load_beat(i, (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0));
    enqueue(test_beat(16'd7, 0, 0, 0, 31'd0));
    enqueue(test_beat(16'd8, 32'sh0002_0000, 0, 0, 31'd0));
    enqueue(test_beat(16'd9, 32'sh0002_0000, 0, 0, 31'h0001_0000));
    enqueue(test_beat(16'd10, 32'sh7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
    wait_drained();

    // Index limit of zero with both index extremes, then culling switched off.
    write_reg(fsc_pkg::CFG_OBJECT_LIMIT, 17'd0);
    enqueue(test_beat(16'd0, 0, 0, 0, 31'd1));
    enqueue(test_beat(16'hFFFF, 0, 0, 0, 31'd1));
    wait_drained();
    write_reg(fsc_pkg::CFG_CULL_ENABLE, 17'd0);
    enqueue(test_beat(16'd3, 32'sh7FFF_0000, 0, 0, 31'd0));
    enqueue(test_beat(16'hFFFF, 0, 0, 0, 31'd0));
    wait_drained();

    // Random phases over several register settings.
    write_reg(fsc_pkg::CFG_CULL_ENABLE, 17'd1);
    write_reg(fsc_pkg::CFG_OBJECT_LIMIT, 17'd65536);
    random_phase(400);
    hold_reqs++;
    random_phase(100);
    wait_drained();
    write_reg(fsc_pkg::CFG_OBJECT_LIMIT, 17'd32768);
    random_phase(350);
    wait_drained();
    write_reg(fsc_pkg::CFG_OBJECT_LIMIT, 17'd65535);
    random_phase(350);
    wait_drained();
    write_reg(fsc_pkg::CFG_CULL_ENABLE, 17'd0);
    random_phase(250);
    wait_drained();
    write_reg(fsc_pkg::CFG_CULL_ENABLE, 17'd1);
    write_reg(fsc_pkg::CFG_OBJECT_LIMIT, 17'd65536);
    quiet = 1'b1;
    random_phase(350);
    wait_drained();

    $display("Covered %0d matrix loads and %0d sphere tests, %0d visible indices checked.",
             n_loads, n_tests, n_seen);
    if (errors == 0 && visible_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/fsc_pkg.sv
src/fsc_datapath.sv
src/fsc_ctrl.sv
src/frustum_sphere_culler.sv
tb/sv/tb_frustum_sphere_culler.sv
